@@ sv/pcf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_pkg - shared types and constants of the command packet framer
// Widths, reset values, register indexes, the command record passed from the
// front end to the byte sequencer, and the sequencer's byte positions.
// ----------------------------------------------------------------------------
package pcf_pkg;

  localparam int DATA_W       = 8;
  localparam int COUNT_W      = 7;
  localparam int LEN_W        = 16;
  localparam int SUM_W        = 16;
  localparam int ADDR_W       = 32;
  localparam int SCODE_W      = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int S_TDATA_W    = 24;
  localparam int POS_W        = 4;

  localparam int MAX_PAYLOAD_DEF = 64;
  localparam int LEN_EXTRA       = 2;

  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = 2;
  localparam int QCNT_W       = 3;

  localparam logic [ADDR_W-1:0]  DEV_ADDR_RST   = 32'hFFFF_FFFF;
  localparam logic [SCODE_W-1:0] START_CODE_RST = 16'hEF01;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEVICE_ADDRESS = 2'd0,
    CFG_START_CODE     = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [ADDR_W-1:0]  dev_addr;
    logic [SCODE_W-1:0] start_code;
  } cfg_t;

  // One accepted payload word, already classified and summed.
  typedef struct packed {
    logic              first;
    logic              last;
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] ptype;
    logic [LEN_W-1:0]  len;
    logic [SUM_W-1:0]  sum;
  } cmd_t;

  typedef enum logic [POS_W-1:0] {
    POS_SC_HI   = 4'd0,
    POS_SC_LO   = 4'd1,
    POS_ADDR_3  = 4'd2,
    POS_ADDR_2  = 4'd3,
    POS_ADDR_1  = 4'd4,
    POS_ADDR_0  = 4'd5,
    POS_TYPE    = 4'd6,
    POS_LEN_HI  = 4'd7,
    POS_LEN_LO  = 4'd8,
    POS_DATA    = 4'd9,
    POS_SUM_HI  = 4'd10,
    POS_SUM_LO  = 4'd11
  } seq_pos_e;

endpackage

@@ sv/pcf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_front - input classifier and checksum accumulator
// Accepts payload words, drops those outside a packet, computes the length
// field and the running checksum, and pushes one command per kept word.
// ----------------------------------------------------------------------------
module pcf_front
  import pcf_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [DATA_W-1:0]  data_i,
  input  logic [DATA_W-1:0]  ptype_i,
  input  logic [COUNT_W-1:0] count_i,
  input  logic               first_i,
  input  logic               last_i,
  input  logic               full_i,
  output logic               push_o,
  output cmd_t               cmd_o
);

  logic             open_q, open_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             accept;
  logic [LEN_W-1:0] cnt_sat;
  logic [LEN_W-1:0] len;
  logic [SUM_W-1:0] hdr_sum;
  logic [SUM_W-1:0] base_sum;
  logic [SUM_W-1:0] new_sum;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;
  assign push_o  = accept && (first_i || open_q);

  // Counts above the limit are clipped for the length field only.
  assign cnt_sat = ((LEN_W+1)'(count_i) > (LEN_W+1)'(MAX_PAYLOAD)) ?
                   LEN_W'(MAX_PAYLOAD) : LEN_W'(count_i);
  assign len      = cnt_sat + LEN_W'(LEN_EXTRA);
  assign hdr_sum  = SUM_W'(len[LEN_W-1:DATA_W]) + SUM_W'(len[DATA_W-1:0]) + SUM_W'(ptype_i);
  assign base_sum = first_i ? hdr_sum : sum_q;
  assign new_sum  = base_sum + SUM_W'(data_i);

  always_comb begin
    open_d = open_q;
    sum_d  = sum_q;
    if (push_o) begin
      open_d = !last_i;
      sum_d  = new_sum;
    end
  end

  assign cmd_o.first = first_i;
  assign cmd_o.last  = last_i;
  assign cmd_o.data  = data_i;
  assign cmd_o.ptype = ptype_i;
  assign cmd_o.len   = len;
  assign cmd_o.sum   = new_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      sum_q  <= '0;
    end else begin
      open_q <= open_d;
      sum_q  <= sum_d;
    end
  end

endmodule

@@ sv/pcf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_queue - small command queue
// Decouples the front end from the byte sequencer; push and pop may happen in
// the same cycle, and the head entry is visible without a pop.
// ----------------------------------------------------------------------------
module pcf_queue
  import pcf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop_i  ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty queue");
`endif

endmodule

@@ sv/pcf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_back - byte sequencer
// Walks each queued command through its byte positions (header, payload,
// checksum) and drives the registered output, one byte per ready cycle.
// ----------------------------------------------------------------------------
module pcf_back
  import pcf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  cmd_t              head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [DATA_W-1:0] byte_o,
  output logic              eof_o
);

  seq_pos_e          pos_q, pos_d;
  logic              active_q, active_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] byte_q, byte_d;
  logic              eof_q, eof_d;
  logic              advance;
  logic              fire;
  seq_pos_e          cur_pos;
  seq_pos_e          end_pos;
  logic              done;
  logic [DATA_W-1:0] sel_byte;

  assign advance = !out_valid_q || ready_i;
  assign fire    = advance && !empty_i;
  assign cur_pos = active_q ? pos_q : (head_i.first ? POS_SC_HI : POS_DATA);
  assign end_pos = head_i.last ? POS_SUM_LO : POS_DATA;
  assign done    = (cur_pos == end_pos);
  assign pop_o   = fire && done;

  // Next position.
  always_comb begin
    pos_d    = pos_q;
    active_d = active_q;
    if (fire) begin
      if (done) begin
        active_d = 1'b0;
      end else begin
        active_d = 1'b1;
        pos_d    = seq_pos_e'(POS_W'(cur_pos) + POS_W'(1));
      end
    end
  end

  // Byte selected at the current position.
  always_comb begin
    unique case (cur_pos)
      POS_SC_HI:  sel_byte = cfg_i.start_code[15:8];
      POS_SC_LO:  sel_byte = cfg_i.start_code[7:0];
      POS_ADDR_3: sel_byte = cfg_i.dev_addr[31:24];
      POS_ADDR_2: sel_byte = cfg_i.dev_addr[23:16];
      POS_ADDR_1: sel_byte = cfg_i.dev_addr[15:8];
      POS_ADDR_0: sel_byte = cfg_i.dev_addr[7:0];
      POS_TYPE:   sel_byte = head_i.ptype;
      POS_LEN_HI: sel_byte = head_i.len[15:8];
      POS_LEN_LO: sel_byte = head_i.len[7:0];
      POS_DATA:   sel_byte = head_i.data;
      POS_SUM_HI: sel_byte = head_i.sum[15:8];
      POS_SUM_LO: sel_byte = head_i.sum[7:0];
      default:    sel_byte = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    eof_d       = eof_q;
    if (advance) begin
      out_valid_d = fire;
      byte_d      = sel_byte;
      eof_d       = (cur_pos == POS_SUM_LO);
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    eof_q  <= eof_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_SC_HI;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign valid_o = out_valid_q;
  assign byte_o  = byte_q;
  assign eof_o   = eof_q;

endmodule

@@ sv/command_packet_framer_with_sum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_packet_framer_with_sum - sensor-module command packet framer
// Turns a stream of payload bytes into framed command packets with a header
// and a 16-bit checksum, emitted as a byte stream.
// ----------------------------------------------------------------------------
// The input side takes one payload word per clock cycle whenever the internal
// four-entry command queue has room. Each kept word becomes one command; the
// output side emits one byte per unstalled cycle: nine header bytes before the
// first word of a packet (start code, big-endian device address, type,
// big-endian length), the payload byte itself, and two checksum bytes after the
// last word. A plain payload word thus yields one output byte, a packet of N
// words yields N + 11 bytes, and the output byte sequencer sets the sustained
// rate. A word that is neither a first byte nor inside an open packet is taken
// and dropped. The output is registered, so a stalled byte does not stop the
// input side until the queue fills. Configuration writes are always accepted
// (cfg_ready_o is tied high) and should only be issued while the block is idle.
// ----------------------------------------------------------------------------
module command_packet_framer_with_sum
  import pcf_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Payload input.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: [7:0] data_byte, [15:8] packet_type, [22:16] payload_count, [23] zero
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // tuser: [0] first_byte
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tlast,
  // Wire byte output.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: [7:0] wire_byte
  output logic [DATA_W-1:0]     m_axis_tdata,
  output logic                  m_axis_tlast,
  // Configuration writes.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  logic push;
  logic pop;
  logic full;
  logic empty;
  cmd_t push_cmd;
  cmd_t head_cmd;

  // Configuration registers. Writes to indexes beyond the list are ignored.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_DEVICE_ADDRESS) begin
        cfg_d.dev_addr = cfg_data_i[ADDR_W-1:0];
      end else if (cfg_index_i == CFG_START_CODE) begin
        cfg_d.start_code = cfg_data_i[SCODE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr   <= DEV_ADDR_RST;
      cfg_q.start_code <= START_CODE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: classification, length and running checksum.
  pcf_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (s_axis_tdata[7:0]),
    .ptype_i (s_axis_tdata[15:8]),
    .count_i (s_axis_tdata[22:16]),
    .first_i (s_axis_tuser),
    .last_i  (s_axis_tlast),
    .full_i  (full),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  // Queue between the two halves.
  pcf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .empty_o (empty)
  );

  // Back end: byte sequencing and output register.
  pcf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .head_i  (head_cmd),
    .empty_i (empty),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .byte_o  (m_axis_tdata),
    .eof_o   (m_axis_tlast)
  );

endmodule
